@@ hw/rtl/crc16_framed_packet_receiver_unit_macros.svh @@
// assertion helpers for the framed packet receiver
`ifndef CRC16_FRAMED_PACKET_RECEIVER_UNIT_MACROS_SVH
`define CRC16_FRAMED_PACKET_RECEIVER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CFPR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CFPR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/cfpr_pkg.sv @@
`timescale 1ns / 1ps
package cfpr_pkg;

    // event codes
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_PAYLOAD   = 3'd1;
    localparam logic [2:0] EV_GOOD      = 3'd2;
    localparam logic [2:0] EV_CRC_ERR   = 3'd3;
    localparam logic [2:0] EV_LEN_ERR   = 3'd4;

    // configuration register indexes
    localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

    // configuration reset values
    localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
    localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
    localparam logic [15:0] MAX_PAYLOAD_RST = 16'd256;

    // crc-16/ccitt-false
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [15:0] max_payload;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [7:0]  command;
        logic [7:0]  sequence_res;
        logic [15:0] payload_length;
        logic [15:0] frame_crc;
    } t_result;

    // one byte of crc update, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/cfpr_regs.sv @@
`timescale 1ns / 1ps
module cfpr_regs import cfpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    // register writes, unknown indexes dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= SYNC_FIRST_RST;
            r_cfg.sync_second <= SYNC_SECOND_RST;
            r_cfg.max_payload <= MAX_PAYLOAD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SYNC_FIRST:  r_cfg.sync_first  <= i_cfg_data[7:0];
                REG_SYNC_SECOND: r_cfg.sync_second <= i_cfg_data[7:0];
                REG_MAX_PAYLOAD: r_cfg.max_payload <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hw/rtl/cfpr_parser.sv @@
`timescale 1ns / 1ps
module cfpr_parser import cfpr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    localparam logic [3:0] PH_SYNC1   = 4'd0;
    localparam logic [3:0] PH_SYNC2   = 4'd1;
    localparam logic [3:0] PH_CMD     = 4'd2;
    localparam logic [3:0] PH_SEQ     = 4'd3;
    localparam logic [3:0] PH_LENL    = 4'd4;
    localparam logic [3:0] PH_LENH    = 4'd5;
    localparam logic [3:0] PH_PAYLOAD = 4'd6;
    localparam logic [3:0] PH_CRCL    = 4'd7;
    localparam logic [3:0] PH_CRCH    = 4'd8;

    logic [3:0]  r_phase,   n_phase;
    logic [15:0] r_crc,     n_crc;
    logic [15:0] r_len,     n_len;
    logic [15:0] r_count,   n_count;
    logic [7:0]  r_cmd,     n_cmd;
    logic [7:0]  r_seq,     n_seq;
    logic [7:0]  r_crc_low, n_crc_low;

    logic [15:0] crc_upd;
    logic [15:0] count_inc;
    logic [15:0] got_crc;

    assign crc_upd   = crc_byte(r_crc, i_byte);
    assign count_inc = r_count + 16'd1;
    assign got_crc   = {i_byte, r_crc_low};

    // one frame step per byte
    always_comb begin
        n_phase   = r_phase;
        n_crc     = r_crc;
        n_len     = r_len;
        n_count   = r_count;
        n_cmd     = r_cmd;
        n_seq     = r_seq;
        n_crc_low = r_crc_low;
        o_result.event_res    = EV_NONE;
        o_result.payload_byte = 8'd0;
        o_result.byte_index   = 16'd0;
        o_result.frame_crc    = 16'd0;
        case (r_phase)
            PH_SYNC1: begin
                if (i_byte == i_cfg.sync_first) begin
                    n_phase = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                if (i_byte == i_cfg.sync_second) begin
                    n_crc   = CRC_INIT;
                    n_count = 16'd0;
                    n_phase = PH_CMD;
                end else begin
                    n_phase = PH_SYNC1;
                end
            end
            PH_CMD: begin
                n_cmd   = i_byte;
                n_crc   = crc_upd;
                n_phase = PH_SEQ;
            end
            PH_SEQ: begin
                n_seq   = i_byte;
                n_crc   = crc_upd;
                n_phase = PH_LENL;
            end
            PH_LENL: begin
                n_len   = {8'd0, i_byte};
                n_crc   = crc_upd;
                n_phase = PH_LENH;
            end
            PH_LENH: begin
                n_len = {i_byte, r_len[7:0]};
                n_crc = crc_upd;
                if (n_len > i_cfg.max_payload) begin
                    o_result.event_res = EV_LEN_ERR;
                    n_phase = PH_SYNC1;
                end else if (n_len == 16'd0) begin
                    n_phase = PH_CRCL;
                end else begin
                    n_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_crc   = crc_upd;
                n_count = count_inc;
                o_result.event_res    = EV_PAYLOAD;
                o_result.payload_byte = i_byte;
                o_result.byte_index   = r_count;
                if (count_inc >= r_len) begin
                    n_phase = PH_CRCL;
                end
            end
            PH_CRCL: begin
                n_crc_low = i_byte;
                n_phase   = PH_CRCH;
            end
            PH_CRCH: begin
                o_result.frame_crc = got_crc;
                o_result.event_res = (got_crc == r_crc) ? EV_GOOD : EV_CRC_ERR;
                n_phase = PH_SYNC1;
            end
            default: begin
                n_phase = PH_SYNC1;
            end
        endcase
        o_result.command        = n_cmd;
        o_result.sequence_res   = n_seq;
        o_result.payload_length = n_len;
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_SYNC1;
            r_crc     <= CRC_INIT;
            r_len     <= 16'd0;
            r_count   <= 16'd0;
            r_cmd     <= 8'd0;
            r_seq     <= 8'd0;
            r_crc_low <= 8'd0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_crc     <= n_crc;
            r_len     <= n_len;
            r_count   <= n_count;
            r_cmd     <= n_cmd;
            r_seq     <= n_seq;
            r_crc_low <= n_crc_low;
        end
    end

endmodule

@@ hw/rtl/crc16_framed_packet_receiver_unit.sv @@
`timescale 1ns / 1ps
// channel   | direction | handshake                | payload
// ----------+-----------+--------------------------+------------------------------------
// input     | in        | i_in_valid / o_in_stall  | i_rx_byte
// result    | out       | o_out_valid / i_out_stall| o_event_res .. o_frame_crc
// config    | in        | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// one byte per cycle while the result is not stalled; a result leaves after its request passes
// the input register, then the frame step with byte-wide crc update into the result register
// reset is synchronous, active low; it returns to sync hunting with default registers
// a stalled result holds; the input register takes one more request behind it, then stalls
// config writes are always ready and act at once
module crc16_framed_packet_receiver_unit import cfpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_byte_index,
    output logic [7:0]  o_command,
    output logic [7:0]  o_sequence_res,
    output logic [15:0] o_payload_length,
    output logic [15:0] o_frame_crc,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

`include "crc16_framed_packet_receiver_unit_macros.svh"

    t_cfg    cfg;
    t_result step_result;
    t_result r_out;
    logic    r_out_valid;
    logic    r_in_valid;
    logic [7:0] r_in_byte;
    logic    in_accept;
    logic    advance;

    assign o_cfg_ready = 1'b1;

    cfpr_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // flow control between the two registers
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_rx_byte;
        end
    end

    cfpr_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (r_in_byte),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= advance || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_event_res      = r_out.event_res;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_byte_index     = r_out.byte_index;
    assign o_command        = r_out.command;
    assign o_sequence_res   = r_out.sequence_res;
    assign o_payload_length = r_out.payload_length;
    assign o_frame_crc      = r_out.frame_crc;

    // checks
    `CFPR_ASSERT_NOW(a_idx_in_len, r_out_valid && (r_out.event_res == EV_PAYLOAD), r_out.byte_index < r_out.payload_length, "payload index beyond frame length")
    `CFPR_ASSERT_NOW(a_crc_only_end, r_out_valid && (r_out.event_res != EV_GOOD) && (r_out.event_res != EV_CRC_ERR), r_out.frame_crc == 16'd0, "trailer crc shown outside frame end")
    `CFPR_ASSERT_NOW(a_stall_full, o_in_stall, r_in_valid && r_out_valid && i_out_stall, "input stalled with room in pipeline")
    `CFPR_ASSERT_NEXT(a_step_out, advance, r_out_valid, "stepped request produced no result")

endmodule

@@ verif/tb_crc16_framed_packet_receiver_unit.sv @@
`timescale 1ns / 1ps
import cfpr_pkg::*;

// where the receiver is in a frame
typedef enum logic [3:0] {
    HUNT_FIRST,
    HUNT_SECOND,
    GET_CMD,
    GET_SEQ,
    LEN_LO,
    LEN_HI,
    GET_PAYLOAD,
    CRC_LO,
    CRC_HI
} rx_parse_e;

class rx_frame_scoreboard;
    // register copies
    logic [7:0]  sync_first  = SYNC_FIRST_RST;
    logic [7:0]  sync_second = SYNC_SECOND_RST;
    logic [15:0] max_payload = MAX_PAYLOAD_RST;

    // frame parse state
    rx_parse_e   parse = HUNT_FIRST;
    logic [15:0] crc_acc = CRC_INIT;
    logic [15:0] frame_len = '0;
    logic [15:0] byte_count = '0;
    logic [7:0]  cmd_q = '0;
    logic [7:0]  seq_q = '0;
    logic [7:0]  crc_lo = '0;

    t_result     expected_events[$];
    int unsigned mismatches = 0;

    // crc-16/ccitt-false, one data bit at a time
    static function logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function void set_reg(input logic [1:0] idx, input logic [15:0] data);
        case (idx)
            REG_SYNC_FIRST:  sync_first = data[7:0];
            REG_SYNC_SECOND: sync_second = data[7:0];
            REG_MAX_PAYLOAD: max_payload = data;
            default: ;
        endcase
    endfunction

    // step the frame parser with one accepted byte and queue its event
    function void note_rx_byte(input logic [7:0] b);
        t_result r;
        r = '0;
        r.event_res = EV_NONE;
        case (parse)
            HUNT_FIRST: begin
                if (b == sync_first) parse = HUNT_SECOND;
            end
            HUNT_SECOND: begin
                // a bad second sync is not retried as a first sync
                if (b == sync_second) begin
                    crc_acc = CRC_INIT;
                    byte_count = '0;
                    parse = GET_CMD;
                end else begin
                    parse = HUNT_FIRST;
                end
            end
            GET_CMD: begin
                cmd_q = b;
                crc_acc = crc16_update(crc_acc, b);
                parse = GET_SEQ;
            end
            GET_SEQ: begin
                seq_q = b;
                crc_acc = crc16_update(crc_acc, b);
                parse = LEN_LO;
            end
            LEN_LO: begin
                frame_len = {8'h00, b};
                crc_acc = crc16_update(crc_acc, b);
                parse = LEN_HI;
            end
            LEN_HI: begin
                frame_len[15:8] = b;
                crc_acc = crc16_update(crc_acc, b);
                if (frame_len > max_payload) begin
                    r.event_res = EV_LEN_ERR;
                    parse = HUNT_FIRST;
                end else if (frame_len == 16'd0) begin
                    parse = CRC_LO;
                end else begin
                    parse = GET_PAYLOAD;
                end
            end
            GET_PAYLOAD: begin
                crc_acc = crc16_update(crc_acc, b);
                r.event_res = EV_PAYLOAD;
                r.payload_byte = b;
                r.byte_index = byte_count;
                byte_count = byte_count + 16'd1;
                if (byte_count >= frame_len) parse = CRC_LO;
            end
            CRC_LO: begin
                crc_lo = b;
                parse = CRC_HI;
            end
            CRC_HI: begin
                r.frame_crc = {b, crc_lo};
                r.event_res = ({b, crc_lo} == crc_acc) ? EV_GOOD : EV_CRC_ERR;
                parse = HUNT_FIRST;
            end
            default: parse = HUNT_FIRST;
        endcase
        r.command = cmd_q;
        r.sequence_res = seq_q;
        r.payload_length = frame_len;
        expected_events.push_back(r);
    endfunction

    function int unsigned pending();
        return expected_events.size();
    endfunction

    function void flag(input string what);
        mismatches++;
        if (mismatches <= 10) $display("[%0t] %s", $time, what);
    endfunction

    function void check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
        if (got !== want) flag($sformatf("%s: expected 0x%0h, got 0x%0h", name, want, got));
    endfunction

    // compare one accepted result with the oldest queued event
    function void check_event(input t_result got);
        t_result want;
        if (expected_events.size() == 0) begin
            flag($sformatf("result with nothing pending, event %0d", got.event_res));
            return;
        end
        want = expected_events.pop_front();
        check_field("event_res", 16'(want.event_res), 16'(got.event_res));
        check_field("payload_byte", 16'(want.payload_byte), 16'(got.payload_byte));
        check_field("byte_index", want.byte_index, got.byte_index);
        check_field("command", 16'(want.command), 16'(got.command));
        check_field("sequence_res", 16'(want.sequence_res), 16'(got.sequence_res));
        check_field("payload_length", want.payload_length, got.payload_length);
        check_field("frame_crc", want.frame_crc, got.frame_crc);
    endfunction
endclass

module tb_crc16_framed_packet_receiver_unit;

    localparam logic [1:0] REG_UNUSED    = 2'd3;
    localparam int unsigned ITEM_TARGET  = 850;
    localparam int unsigned PHASE_ITEMS  = 130;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned RUN_LIMIT_NS = 3_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_event_res;
    logic [7:0]  o_payload_byte;
    logic [15:0] o_byte_index;
    logic [7:0]  o_command;
    logic [7:0]  o_sequence_res;
    logic [15:0] o_payload_length;
    logic [15:0] o_frame_crc;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    rx_frame_scoreboard sb = new();
    int unsigned items_sent = 0;
    bit          steady_input = 1'b0;

    crc16_framed_packet_receiver_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_event_res      (o_event_res),
        .o_payload_byte   (o_payload_byte),
        .o_byte_index     (o_byte_index),
        .o_command        (o_command),
        .o_sequence_res   (o_sequence_res),
        .o_payload_length (o_payload_length),
        .o_frame_crc      (o_frame_crc),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // send one byte request, with a random gap unless in a steady stretch
    task automatic push_byte(input logic [7:0] b);
        int unsigned sel;
        int unsigned gap;
        sel = $urandom_range(0, 99);
        if (steady_input || sel < 55) gap = 0;
        else if (sel < 85) gap = $urandom_range(1, 2);
        else if (sel < 97) gap = $urandom_range(3, 8);
        else gap = $urandom_range(15, 60);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_rx_byte(b);
    endtask

    // build a frame with the current sync bytes, optionally bad crc or cut short
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] seq,
                              input logic [15:0] len, input bit bad_crc, input bit cut_short);
        logic [7:0]  bytes[$];
        logic [7:0]  pb;
        logic [15:0] crc;
        int unsigned keep;
        int unsigned i;
        bytes = {sb.sync_first, sb.sync_second, cmd, seq, len[7:0], len[15:8]};
        crc = CRC_INIT;
        for (i = 2; i < 6; i++) crc = sb.crc16_update(crc, bytes[i]);
        if (len <= sb.max_payload) begin
            for (i = 0; i < len; i++) begin
                pb = 8'($urandom);
                bytes.push_back(pb);
                crc = sb.crc16_update(crc, pb);
            end
            if (bad_crc) crc = crc ^ 16'($urandom_range(1, 65535));
            bytes.push_back(crc[7:0]);
            bytes.push_back(crc[15:8]);
        end
        keep = bytes.size();
        if (cut_short && keep > 7) keep = $urandom_range(7, keep - 1);
        for (i = 0; i < keep; i++) push_byte(bytes[i]);
        items_sent += keep;
    endtask

    // let every pending event come out, then settle with input idle
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write all registers back to back, optionally poking the unused index
    task automatic load_config(input logic [7:0] first, input logic [7:0] second,
                               input logic [15:0] limit, input bit poke_unused);
        logic [1:0]  idx[$];
        logic [15:0] val[$];
        int unsigned i;
        idx = {REG_SYNC_FIRST, REG_SYNC_SECOND, REG_MAX_PAYLOAD};
        val = {{8'($urandom), first}, {8'($urandom), second}, limit};
        if (poke_unused) begin
            idx.push_front(REG_UNUSED);
            val.push_front(16'($urandom));
        end
        for (i = 0; i < idx.size(); i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_data <= val[i];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            sb.set_reg(idx[i], val[i]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // random result stall: short bursts, rare long holds, some free stretches
    initial begin
        int unsigned sel;
        int unsigned stall_len;
        int unsigned free_len;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            sel = $urandom_range(0, 99);
            free_len = $urandom_range(1, 8);
            if (sel < 45) stall_len = 0;
            else if (sel < 85) stall_len = $urandom_range(1, 3);
            else if (sel < 95) stall_len = $urandom_range(8, 40);
            else begin
                stall_len = 0;
                free_len = $urandom_range(50, 200);
            end
            if (stall_len > 0) begin
                i_out_stall <= 1'b1;
                repeat (stall_len) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat (free_len) @(posedge i_clk);
        end
    end

    // accepted results
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_event({o_event_res, o_payload_byte, o_byte_index, o_command,
                            o_sequence_res, o_payload_length, o_frame_crc});
        end
    end

    initial begin
        int unsigned ph;
        int unsigned sel;
        int unsigned lsel;
        int unsigned phase_stop;
        int unsigned n;
        logic [15:0] len;
        logic [15:0] limit;
        logic [7:0]  b;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset register values
        // bad second sync, then the retried byte must not restart a frame
        push_byte(sb.sync_first);
        push_byte(sb.sync_first);
        push_byte(sb.sync_second);
        items_sent += 3;
        // length one above the reset limit
        send_frame(8'h00, 8'hFF, 16'h0101, 1'b0, 1'b0);
        // empty payload goes straight to the trailer
        send_frame(8'hFF, 8'h00, 16'h0000, 1'b0, 1'b0);
        // single payload byte with a corrupted trailer
        send_frame(8'h5A, 8'hA5, 16'h0001, 1'b1, 1'b0);

        // random phases, each under its own register setting
        for (ph = 0; items_sent < ITEM_TARGET; ph++) begin
            drain_results();
            case (ph)
                0: load_config(8'h00, 8'hFF, 16'h0000, 1'b1);
                1: load_config(8'hFF, 8'h00, 16'hFFFF, 1'b1);
                2: load_config(8'h7E, 8'h7E, 16'd12, 1'($urandom));
                3: load_config(SYNC_FIRST_RST, SYNC_SECOND_RST, MAX_PAYLOAD_RST, 1'($urandom));
                default: begin
                    limit = ($urandom_range(0, 9) == 0) ? 16'hFFFF
                                                        : 16'($urandom_range(0, 300));
                    load_config(8'($urandom), 8'($urandom), limit, 1'($urandom));
                end
            endcase
            steady_input = ($urandom_range(0, 3) == 0);
            phase_stop = items_sent + PHASE_ITEMS;
            while (items_sent < phase_stop && items_sent < ITEM_TARGET) begin
                sel = $urandom_range(0, 99);
                if (sel < 82) begin
                    // mostly short payloads, a few long ones, some over the limit
                    lsel = $urandom_range(0, 99);
                    if (lsel < 92 || sb.max_payload == 16'hFFFF) begin
                        if (lsel < 60) len = 16'($urandom_range(0, 6));
                        else if (lsel < 88) len = 16'($urandom_range(7, 40));
                        else if (sb.max_payload > 300) len = 16'($urandom_range(41, 300));
                        else len = sb.max_payload;
                        if (len > sb.max_payload) len = sb.max_payload;
                    end else begin
                        len = 16'($urandom_range(32'(sb.max_payload) + 1, 65535));
                    end
                    send_frame(8'($urandom), 8'($urandom), len,
                               ($urandom_range(0, 5) == 0), (sel >= 72));
                end else if (sel < 90) begin
                    // first sync followed by anything but the second
                    b = 8'($urandom);
                    if (b == sb.sync_second) b = b ^ 8'h01;
                    push_byte(sb.sync_first);
                    push_byte(b);
                    items_sent += 2;
                end else begin
                    // line noise
                    n = $urandom_range(1, 6);
                    repeat (n) push_byte(8'($urandom));
                    items_sent += n;
                end
            end
        end

        drain_results();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // hang guard
    initial begin
        #(RUN_LIMIT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/cfpr_pkg.sv
hw/rtl/cfpr_regs.sv
hw/rtl/cfpr_parser.sv
hw/rtl/crc16_framed_packet_receiver_unit.sv
verif/tb_crc16_framed_packet_receiver_unit.sv
